// ===== design/tocp_pkg.sv =====
// ----------------------------------------------------------------------------
// Offset table lookup: shared package
// Default sizes, field widths, item kinds, result codes and controller states.
// ----------------------------------------------------------------------------
package tocp_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int MAX_FANOUT_DEF  = 64;
   localparam int ID_BITS_DEF     = 20;

   localparam int KIND_BITS   = 2;
   localparam int INDEX_BITS  = 10;
   localparam int NODE_BITS   = 20;
   localparam int STATUS_BITS = 3;
   localparam int COUNT_BITS  = 10;

   // Wide enough for any index into a table of the largest supported depth.
   localparam int WIDE_INDEX_BITS = 17;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOAD     = 2'd0,
      KIND_CHILDREN = 2'd1,
      KIND_PARENT   = 2'd2,
      KIND_ROOTS    = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 3'd0,
      STATUS_RANGE = 3'd1,
      STATUS_ROOT  = 3'd2,
      STATUS_EMPTY = 3'd3,
      STATUS_TRUNC = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_BEGIN,
      ST_END,
      ST_EMIT,
      ST_SCAN,
      ST_CHECK
   } state_type;

endpackage

// ===== design/tocp_table_mem.sv =====
// ----------------------------------------------------------------------------
// Offset table memory
// Single-port synchronous memory: one access per cycle, a write also reading
// back the old entry, with the read data registered.
// ----------------------------------------------------------------------------
module tocp_table_mem #(
   parameter int DEPTH     = tocp_pkg::TABLE_DEPTH_DEF,
   parameter int DATA_BITS = tocp_pkg::ID_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_BITS-1:0]     wdata,
   output logic [DATA_BITS-1:0]     rdata
);

   logic [DATA_BITS-1:0] entry_ff [DEPTH];
   logic [DATA_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         entry_ff[addr] <= wdata;
      end
      rdata_ff <= entry_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/tocp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Offset table lookup: sequencer
// Walks the table memory one read per cycle for each query and produces the
// registered result stream.
// ----------------------------------------------------------------------------
module tocp_ctrl #(
   parameter int TABLE_DEPTH = tocp_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_FANOUT  = tocp_pkg::MAX_FANOUT_DEF,
   parameter int ID_BITS     = tocp_pkg::ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tocp_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [tocp_pkg::INDEX_BITS-1:0]  req_entry_index,
   input  logic [tocp_pkg::NODE_BITS-1:0]   req_offset_value,
   input  logic [tocp_pkg::NODE_BITS-1:0]   req_node,
   input  logic [tocp_pkg::COUNT_BITS-1:0]  range_count,
   output logic                             mem_we,
   output logic [$clog2(TABLE_DEPTH)-1:0]   mem_addr,
   output logic [ID_BITS-1:0]               mem_wdata,
   input  logic [ID_BITS-1:0]               mem_rdata,
   output logic                             rsp_valid,
   output logic [tocp_pkg::NODE_BITS-1:0]   rsp_node_id,
   output logic [tocp_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                             rsp_last
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int WB = (ID_BITS > tocp_pkg::NODE_BITS) ? ID_BITS : tocp_pkg::NODE_BITS;
   localparam int CW = $clog2(MAX_FANOUT + 1);
   localparam int XW = tocp_pkg::WIDE_INDEX_BITS;
   localparam logic [XW-1:0] RC_LIMIT   = XW'(TABLE_DEPTH - 1);
   localparam logic [XW-1:0] DEPTH_WIDE = XW'(TABLE_DEPTH);

   tocp_pkg::state_type  state_ff, state_in;
   tocp_pkg::kind_type   kind_ff, kind_in;
   logic [tocp_pkg::NODE_BITS-1:0] node_ff, node_in;
   logic [ID_BITS-1:0]   cur_ff, cur_in;
   logic [AW-1:0]        p_ff, p_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic                 trunc_ff, trunc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [tocp_pkg::NODE_BITS-1:0] node_id_ff, node_id_in;
   tocp_pkg::status_type status_ff, status_in;
   logic                 last_ff, last_in;

   tocp_pkg::kind_type   req_kind_t;
   logic [XW-1:0]        rc_wide, eidx_wide;
   logic [AW-1:0]        rc, p_inc;
   logic [WB-1:0]        node_w, data_w, rc_w, cur_w, node_addr_w, len_w, oval_w;
   logic [ID_BITS-1:0]   run_begin, run_len, run_len_m1;
   logic                 run_trunc;

   assign req_kind_t = tocp_pkg::kind_type'(req_kind);

   // A range count beyond the table acts as the last table position.
   assign rc_wide   = XW'(range_count);
   assign rc        = (rc_wide > RC_LIMIT) ? RC_LIMIT[AW-1:0] : rc_wide[AW-1:0];
   assign eidx_wide = XW'(req_entry_index);
   assign p_inc     = p_ff + AW'(1);

   assign node_w      = WB'(node_ff);
   assign data_w      = WB'(mem_rdata);
   assign rc_w        = WB'(rc);
   assign cur_w       = WB'(cur_ff);
   assign node_addr_w = node_w + WB'(1);
   assign oval_w      = WB'(req_offset_value);

   // Run length: roots runs start at zero, children runs at the stored begin.
   assign run_begin  = (state_ff == tocp_pkg::ST_TOTAL) ? '0 : cur_ff;
   assign run_len    = mem_rdata - run_begin;
   assign run_len_m1 = run_len - ID_BITS'(1);
   assign len_w      = WB'(run_len);
   assign run_trunc  = len_w > WB'(MAX_FANOUT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tocp_pkg::ST_IDLE: begin
            if (start && req_kind_t != tocp_pkg::KIND_LOAD) begin
               state_in = tocp_pkg::ST_TOTAL;
            end
         end
         tocp_pkg::ST_TOTAL: begin
            priority if (kind_ff == tocp_pkg::KIND_ROOTS) begin
               state_in = (mem_rdata == '0) ? tocp_pkg::ST_IDLE : tocp_pkg::ST_EMIT;
            end else if (node_w >= data_w) begin
               state_in = tocp_pkg::ST_IDLE;
            end else if (kind_ff == tocp_pkg::KIND_CHILDREN) begin
               state_in = (node_w >= rc_w) ? tocp_pkg::ST_IDLE : tocp_pkg::ST_BEGIN;
            end else begin
               state_in = (rc == '0) ? tocp_pkg::ST_IDLE : tocp_pkg::ST_SCAN;
            end
         end
         tocp_pkg::ST_BEGIN: begin
            state_in = tocp_pkg::ST_END;
         end
         tocp_pkg::ST_END: begin
            state_in = (mem_rdata <= cur_ff) ? tocp_pkg::ST_IDLE : tocp_pkg::ST_EMIT;
         end
         tocp_pkg::ST_EMIT: begin
            if (remain_ff == '0) begin
               state_in = tocp_pkg::ST_IDLE;
            end
         end
         tocp_pkg::ST_SCAN: begin
            priority if (data_w > node_w) begin
               state_in = tocp_pkg::ST_CHECK;
            end else if (p_inc == rc) begin
               state_in = tocp_pkg::ST_IDLE;
            end
         end
         tocp_pkg::ST_CHECK: begin
            state_in = tocp_pkg::ST_IDLE;
         end
         default: begin
            state_in = tocp_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory accesses, working registers and the result register.
   always_comb begin
      kind_in      = kind_ff;
      node_in      = node_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      remain_in    = remain_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = 1'b0;
      node_id_in   = node_id_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      mem_we       = 1'b0;
      mem_addr     = rc;
      mem_wdata    = oval_w[ID_BITS-1:0];

      unique case (state_ff)
         tocp_pkg::ST_IDLE: begin
            if (start) begin
               kind_in = req_kind_t;
               node_in = req_node;
               priority if (req_kind_t == tocp_pkg::KIND_LOAD) begin
                  mem_we   = eidx_wide < DEPTH_WIDE;
                  mem_addr = eidx_wide[AW-1:0];
               end else if (req_kind_t == tocp_pkg::KIND_ROOTS) begin
                  mem_addr = '0;
               end else begin
                  mem_addr = rc;
               end
            end
         end
         tocp_pkg::ST_TOTAL: begin
            priority if (kind_ff == tocp_pkg::KIND_ROOTS) begin
               cur_in    = '0;
               trunc_in  = run_trunc;
               remain_in = run_trunc ? CW'(MAX_FANOUT - 1) : run_len_m1[CW-1:0];
               if (mem_rdata == '0) begin
                  rsp_valid_in = 1'b1;
                  node_id_in   = '0;
                  status_in    = tocp_pkg::STATUS_EMPTY;
                  last_in      = 1'b1;
               end
            end else if (node_w >= data_w) begin
               rsp_valid_in = 1'b1;
               node_id_in   = '0;
               status_in    = tocp_pkg::STATUS_RANGE;
               last_in      = 1'b1;
            end else if (kind_ff == tocp_pkg::KIND_CHILDREN) begin
               mem_addr = node_w[AW-1:0];
               if (node_w >= rc_w) begin
                  rsp_valid_in = 1'b1;
                  node_id_in   = '0;
                  status_in    = tocp_pkg::STATUS_EMPTY;
                  last_in      = 1'b1;
               end
            end else begin
               p_in     = '0;
               mem_addr = AW'(1);
               if (rc == '0) begin
                  rsp_valid_in = 1'b1;
                  node_id_in   = node_ff;
                  status_in    = tocp_pkg::STATUS_ROOT;
                  last_in      = 1'b1;
               end
            end
         end
         tocp_pkg::ST_BEGIN: begin
            cur_in   = mem_rdata;
            mem_addr = node_addr_w[AW-1:0];
         end
         tocp_pkg::ST_END: begin
            trunc_in  = run_trunc;
            remain_in = run_trunc ? CW'(MAX_FANOUT - 1) : run_len_m1[CW-1:0];
            if (mem_rdata <= cur_ff) begin
               rsp_valid_in = 1'b1;
               node_id_in   = '0;
               status_in    = tocp_pkg::STATUS_EMPTY;
               last_in      = 1'b1;
            end
         end
         tocp_pkg::ST_EMIT: begin
            rsp_valid_in = 1'b1;
            node_id_in   = cur_w[tocp_pkg::NODE_BITS-1:0];
            last_in      = remain_ff == '0;
            status_in    = (remain_ff == '0 && trunc_ff) ? tocp_pkg::STATUS_TRUNC
                                                         : tocp_pkg::STATUS_OK;
            cur_in       = cur_ff + ID_BITS'(1);
            remain_in    = remain_ff - CW'(1);
         end
         tocp_pkg::ST_SCAN: begin
            // The entry read here is the upper bound of range p.
            priority if (data_w > node_w) begin
               mem_addr = p_ff;
            end else if (p_inc == rc) begin
               rsp_valid_in = 1'b1;
               node_id_in   = node_ff;
               status_in    = tocp_pkg::STATUS_ROOT;
               last_in      = 1'b1;
            end else begin
               p_in     = p_inc;
               mem_addr = p_inc + AW'(1);
            end
         end
         tocp_pkg::ST_CHECK: begin
            rsp_valid_in = 1'b1;
            last_in      = 1'b1;
            if (data_w <= node_w) begin
               node_id_in = tocp_pkg::NODE_BITS'(p_ff);
               status_in  = tocp_pkg::STATUS_OK;
            end else begin
               node_id_in = node_ff;
               status_in  = tocp_pkg::STATUS_ROOT;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tocp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      node_ff    <= node_in;
      cur_ff     <= cur_in;
      p_ff       <= p_in;
      remain_ff  <= remain_in;
      trunc_ff   <= trunc_in;
      node_id_ff <= node_id_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
   end

   assign busy        = state_ff != tocp_pkg::ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_node_id = node_id_ff;
   assign rsp_status  = status_ff;
   assign rsp_last    = last_ff;

endmodule

// ===== design/tree_offset_child_parent_lookup.sv =====
// ----------------------------------------------------------------------------
// Offset table lookup for a level-ordered forest
// Children, parent and roots queries over a loaded table of range offsets.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. Results leave on
// rsp_valid for exactly one cycle each and cannot be held off, so the
// receiver must take every strobe. All timing is set by the single-port
// offset table, which serves one read per cycle. A load gives no result. A
// children query reads the total and its range bounds, then emits its ids
// (at most MAX_FANOUT). A roots query reads entry zero, then emits the root
// ids. A parent query reads the total, scans upper bounds (up to the range
// count), then checks that range's lower bound. The last result is on the
// result ports in the first cycle in which busy is low again. There is no
// clearing pass after reset: table entries are meaningful once loaded.
module tree_offset_child_parent_lookup #(
   parameter int TABLE_DEPTH = tocp_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_FANOUT  = tocp_pkg::MAX_FANOUT_DEF,
   parameter int ID_BITS     = tocp_pkg::ID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [tocp_pkg::KIND_BITS-1:0]   req_kind,
   input  logic [tocp_pkg::INDEX_BITS-1:0]  req_entry_index,
   input  logic [tocp_pkg::NODE_BITS-1:0]   req_offset_value,
   input  logic [tocp_pkg::NODE_BITS-1:0]   req_node,
   output logic                             rsp_valid,
   output logic [tocp_pkg::NODE_BITS-1:0]   rsp_node_id,
   output logic [tocp_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                             rsp_last,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [2:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [tocp_pkg::COUNT_BITS-1:0] range_count_ff, range_count_in;
   logic                            mem_we;
   logic [AW-1:0]                   mem_addr;
   logic [ID_BITS-1:0]              mem_wdata, mem_rdata;

   // The only register answers at byte addresses zero to three (paddr[2] low); addresses four and up read zero.
   always_comb begin
      range_count_in = range_count_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         range_count_in = pwdata[tocp_pkg::COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_count_ff <= '0;
      end else begin
         range_count_ff <= range_count_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : 32'(range_count_ff);

   tocp_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_FANOUT  (MAX_FANOUT),
      .ID_BITS     (ID_BITS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_offset_value (req_offset_value),
      .req_node         (req_node),
      .range_count      (range_count_ff),
      .mem_we           (mem_we),
      .mem_addr         (mem_addr),
      .mem_wdata        (mem_wdata),
      .mem_rdata        (mem_rdata),
      .rsp_valid        (rsp_valid),
      .rsp_node_id      (rsp_node_id),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   tocp_table_mem #(
      .DEPTH     (TABLE_DEPTH),
      .DATA_BITS (ID_BITS)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule

// ===== tb/tree_offset_child_parent_lookup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Offset table lookup testbench
// Loads forest offset tables through the item port, sets the range count over
// the register port, issues children, parent and roots queries with random
// sender gaps, and checks every result strobe against a local predictor.
// ----------------------------------------------------------------------------
module tree_offset_child_parent_lookup_test;

   localparam logic [2:0] RANGE_COUNT_ADDR = 3'd0;
   localparam int         FANOUT_LIMIT     = tocp_pkg::MAX_FANOUT_DEF;
   localparam int         DEPTH            = tocp_pkg::TABLE_DEPTH_DEF;
   localparam int         SETTLE_LIMIT     = 20000;
   localparam int         ID_WIDTH         = tocp_pkg::NODE_BITS;
   localparam int         IDX_WIDTH        = tocp_pkg::INDEX_BITS;

   typedef struct {
      logic [tocp_pkg::NODE_BITS-1:0] node_id;
      tocp_pkg::status_type           status;
      logic                           last;
   } lookup_result_type;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic [tocp_pkg::KIND_BITS-1:0]   req_kind;
   logic [tocp_pkg::INDEX_BITS-1:0]  req_entry_index;
   logic [tocp_pkg::NODE_BITS-1:0]   req_offset_value;
   logic [tocp_pkg::NODE_BITS-1:0]   req_node;
   logic                             rsp_valid;
   logic [tocp_pkg::NODE_BITS-1:0]   rsp_node_id;
   logic [tocp_pkg::STATUS_BITS-1:0] rsp_status;
   logic                             rsp_last;
   logic                             psel;
   logic                             penable;
   logic                             pwrite;
   logic [2:0]                       paddr;
   logic [31:0]                      pwdata;
   logic [31:0]                      prdata;
   logic                             pready;

   lookup_result_type              pending_results[$];
   logic [tocp_pkg::NODE_BITS-1:0] offset_table_model[DEPTH];
   int unsigned                    range_count_model = 0;
   int                             mismatch_count    = 0;
   int                             gap_percent       = 20;

   tree_offset_child_parent_lookup i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_entry_index  (req_entry_index),
      .req_offset_value (req_offset_value),
      .req_node         (req_node),
      .rsp_valid        (rsp_valid),
      .rsp_node_id      (rsp_node_id),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic void note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
   endfunction

   function automatic void push_expected(input int unsigned id,
                                         input tocp_pkg::status_type st,
                                         input logic last);
      lookup_result_type r;
      r.node_id = ID_WIDTH'(id);
      r.status  = st;
      r.last    = last;
      pending_results.push_back(r);
   endfunction

   // Ids first .. stop-1, cut at the fan-out limit with the final one marked.
   function automatic void expect_child_run(input int unsigned first,
                                            input int unsigned stop);
      int unsigned len;
      int unsigned n;
      if (stop <= first) begin
         push_expected(0, tocp_pkg::STATUS_EMPTY, 1'b1);
      end else begin
         len = stop - first;
         n   = (len > FANOUT_LIMIT) ? FANOUT_LIMIT : len;
         for (int unsigned i = 0; i < n; i++)
            push_expected(first + i,
                          (i + 1 == n && len > n) ? tocp_pkg::STATUS_TRUNC
                                                  : tocp_pkg::STATUS_OK,
                          i + 1 == n);
      end
   endfunction

   function automatic void predict_lookup(input tocp_pkg::kind_type k,
                                          input logic [tocp_pkg::INDEX_BITS-1:0] idx,
                                          input logic [tocp_pkg::NODE_BITS-1:0] val,
                                          input logic [tocp_pkg::NODE_BITS-1:0] nd);
      int unsigned total;
      int unsigned p;
      total = 32'(offset_table_model[range_count_model]);
      case (k)
         tocp_pkg::KIND_LOAD: begin
            offset_table_model[idx] = val;
         end
         tocp_pkg::KIND_ROOTS: begin
            expect_child_run(0, 32'(offset_table_model[0]));
         end
         default: begin
            if (nd >= total) begin
               push_expected(0, tocp_pkg::STATUS_RANGE, 1'b1);
            end else if (k == tocp_pkg::KIND_CHILDREN) begin
               if (nd >= range_count_model)
                  push_expected(0, tocp_pkg::STATUS_EMPTY, 1'b1);
               else
                  expect_child_run(32'(offset_table_model[nd]),
                                   32'(offset_table_model[nd + 1]));
            end else begin
               // The parent is the first range whose upper bound lies above the node.
               p = 0;
               while (p < range_count_model && offset_table_model[p + 1] <= nd) p++;
               if (p < range_count_model && offset_table_model[p] <= nd)
                  push_expected(p, tocp_pkg::STATUS_OK, 1'b1);
               else
                  push_expected(32'(nd), tocp_pkg::STATUS_ROOT, 1'b1);
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            note_mismatch($sformatf("unexpected result: node_id %0d status %0d last %0d",
                                    rsp_node_id, rsp_status, rsp_last));
         end else begin
            want = pending_results.pop_front();
            if (rsp_node_id !== want.node_id)
               note_mismatch($sformatf("node_id: expected %0d, got %0d",
                                       want.node_id, rsp_node_id));
            if (rsp_status !== want.status)
               note_mismatch($sformatf("status: expected %0d, got %0d (node_id %0d)",
                                       want.status, rsp_status, want.node_id));
            if (rsp_last !== want.last)
               note_mismatch($sformatf("last: expected %0d, got %0d (node_id %0d)",
                                       want.last, rsp_last, want.node_id));
         end
      end
   end

   // Start is left high after acceptance so that back-to-back transactions
   // need no second assignment in the same time step.
   task automatic issue_item(input tocp_pkg::kind_type k,
                             input logic [tocp_pkg::INDEX_BITS-1:0] idx,
                             input logic [tocp_pkg::NODE_BITS-1:0] val,
                             input logic [tocp_pkg::NODE_BITS-1:0] nd);
      if ($urandom_range(99, 0) < gap_percent) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= k;
      req_entry_index  <= idx;
      req_offset_value <= val;
      req_node         <= nd;
      do @(posedge clock); while (busy);
      predict_lookup(k, idx, val, nd);
   endtask

   task automatic load_entry(input logic [tocp_pkg::INDEX_BITS-1:0] idx,
                             input logic [tocp_pkg::NODE_BITS-1:0] val);
      issue_item(tocp_pkg::KIND_LOAD, idx, val, ID_WIDTH'($urandom()));
   endtask

   task automatic ask(input tocp_pkg::kind_type k,
                      input logic [tocp_pkg::NODE_BITS-1:0] nd);
      issue_item(k, IDX_WIDTH'($urandom()), ID_WIDTH'($urandom()), nd);
   endtask

   task automatic settle_block();
      int waited;
      start  <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while ((busy || pending_results.size() != 0) && waited < SETTLE_LIMIT);
      repeat (4) @(posedge clock);
   endtask

   // Write the range count, then read it back straight after.
   task automatic csr_set_range_count(input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= RANGE_COUNT_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      range_count_model = value;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(range_count_model))
         note_mismatch($sformatf("range_count read: expected %0d, got %0d",
                                 range_count_model, prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // No ranges at all: every node below the total is a root.
   task automatic test_single_range_forest();
      settle_block();
      csr_set_range_count(0);
      load_entry(0, 5);
      ask(tocp_pkg::KIND_ROOTS, 0);
      ask(tocp_pkg::KIND_CHILDREN, 0);
      ask(tocp_pkg::KIND_PARENT, 3);
      ask(tocp_pkg::KIND_CHILDREN, 5);
      ask(tocp_pkg::KIND_PARENT, 20'hFFFFF);
      load_entry(0, 0);
      ask(tocp_pkg::KIND_ROOTS, 0);
      ask(tocp_pkg::KIND_PARENT, 0);
   endtask

   // Four ranges: a single child, an empty range, a run just past the fan-out
   // limit and one exactly at it.
   task automatic test_small_forest();
      settle_block();
      csr_set_range_count(4);
      load_entry(0, 2);
      load_entry(1, 3);
      load_entry(2, 3);
      load_entry(3, 70);
      load_entry(4, 134);
      ask(tocp_pkg::KIND_CHILDREN, 0);
      ask(tocp_pkg::KIND_CHILDREN, 1);
      ask(tocp_pkg::KIND_CHILDREN, 2);
      ask(tocp_pkg::KIND_CHILDREN, 3);
      ask(tocp_pkg::KIND_CHILDREN, 4);
      ask(tocp_pkg::KIND_CHILDREN, 134);
      ask(tocp_pkg::KIND_PARENT, 1);
      ask(tocp_pkg::KIND_PARENT, 2);
      ask(tocp_pkg::KIND_PARENT, 3);
      ask(tocp_pkg::KIND_PARENT, 69);
      ask(tocp_pkg::KIND_PARENT, 70);
      ask(tocp_pkg::KIND_PARENT, 133);
      ask(tocp_pkg::KIND_PARENT, 134);
      ask(tocp_pkg::KIND_ROOTS, 0);
      load_entry(IDX_WIDTH'(DEPTH - 1), 20'hFFFFF);
      load_entry(0, 65);
      ask(tocp_pkg::KIND_ROOTS, 0);
   endtask

   task automatic test_random_traffic(input int gap, input int unsigned ranges,
                                      input int count);
      int unsigned                    running;
      int unsigned                    total;
      int unsigned                    pick;
      logic [tocp_pkg::NODE_BITS-1:0] nd;
      tocp_pkg::kind_type             k;
      gap_percent = gap;
      settle_block();
      csr_set_range_count(ranges);
      // Build a well-formed table over every entry the queries can reach.
      running = $urandom_range(3, 0);
      for (int unsigned i = 0; i <= ranges; i++) begin
         load_entry(IDX_WIDTH'(i), ID_WIDTH'(running));
         pick = $urandom_range(15, 0);
         if (pick == 0)
            running += $urandom_range(70, 60);
         else if (pick >= 4)
            running += $urandom_range(3, 1);
      end
      for (int n = 0; n < count; n++) begin
         total = 32'(offset_table_model[range_count_model]);
         pick  = $urandom_range(99, 0);
         nd    = ID_WIDTH'($urandom_range(total + 1, 0));
         k     = (pick < 45) ? tocp_pkg::KIND_CHILDREN : tocp_pkg::KIND_PARENT;
         // A few loads land anywhere with any value, breaking the ordering.
         if (pick < 8)
            k = tocp_pkg::KIND_LOAD;
         else if (pick < 45 && $urandom_range(3, 0) != 0)
            nd = ID_WIDTH'($urandom_range(ranges, 0));
         else if (pick >= 80 && pick < 92)
            k = tocp_pkg::KIND_ROOTS;
         else if (pick >= 92)
            nd = ID_WIDTH'($urandom());
         issue_item(k, IDX_WIDTH'($urandom()), ID_WIDTH'($urandom()), nd);
      end
   endtask

   initial begin
      start            <= 1'b0;
      req_kind         <= tocp_pkg::KIND_LOAD;
      req_entry_index  <= '0;
      req_offset_value <= '0;
      req_node         <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= RANGE_COUNT_ADDR;
      pwdata           <= '0;
      reset            <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_single_range_forest();
      test_small_forest();
      test_random_traffic(20, $urandom_range(40, 5), 80);
      test_random_traffic(50, $urandom_range(60, 20), 80);
      test_random_traffic(0, $urandom_range(12, 1), 80);
      settle_block();

      if (pending_results.size() != 0)
         note_mismatch($sformatf("%0d expected results never arrived",
                                 pending_results.size()));
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
